// ===== sv/ptru_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptru_pkg
// shared types and constants for the privilege trap and return unit
// ----------------------------------------------------------------------------
package ptru_pkg;

   localparam int unsigned XLEN = 32;

   typedef logic [XLEN-1:0] xword_type;

   typedef enum logic [1:0] {
      OP_ECALL = 2'd0,
      OP_SRET  = 2'd1,
      OP_MRET  = 2'd2,
      OP_WFI   = 2'd3
   } op_type;

   typedef logic [1:0] priv_type;

   localparam priv_type PRIV_U = 2'd0;
   localparam priv_type PRIV_S = 2'd1;
   localparam priv_type PRIV_M = 2'd3;

   typedef logic [2:0] exc_type;

   localparam exc_type EXC_NONE    = 3'd0;
   localparam exc_type EXC_ILLEGAL = 3'd1;
   localparam exc_type EXC_ECALL_U = 3'd2;
   localparam exc_type EXC_ECALL_S = 3'd3;
   localparam exc_type EXC_ECALL_M = 3'd4;

   // mstatus bit positions
   localparam int unsigned ST_SIE  = 1;
   localparam int unsigned ST_MIE  = 3;
   localparam int unsigned ST_SPIE = 5;
   localparam int unsigned ST_MPIE = 7;
   localparam int unsigned ST_SPP  = 8;
   localparam int unsigned ST_MPP  = 11;
   localparam int unsigned ST_MPRV = 17;
   localparam int unsigned ST_TW   = 21;
   localparam int unsigned ST_TSR  = 22;

endpackage

// ===== sv/privilege_trap_return_unit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// privilege_trap_return_unit_core
// executes ecall, sret, mret and wfi against the current privilege and mstatus
// ----------------------------------------------------------------------------
// usage
//    an instruction is handed over with start high while busy is low; busy is
//    never raised, so one instruction may be given on every clock cycle
//    req_mode selects ecall, sret, mret or wfi; req_cur_priv, req_status_in,
//    req_sup_epc and req_mach_epc carry the architectural state it acts on
//    the result follows the transfer and shows for one cycle, marked
//    by rsp_valid: the request is captured in an input register, decoded by
//    one level of logic and captured again in the result register
//    throughput is one instruction per cycle
//    rsp_exc_code reports an ecall cause or an illegal instruction; a trap
//    leaves privilege and mstatus unchanged with no redirect or standby
//    a synchronous reset drops any instruction in flight and clears rsp_valid
//    the receiver cannot stall: every result is taken in its one valid cycle
// ----------------------------------------------------------------------------
module privilege_trap_return_unit_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_mode,
   input  ptru_pkg::priv_type req_cur_priv,
   input  ptru_pkg::xword_type req_status_in,
   input  ptru_pkg::xword_type req_sup_epc,
   input  ptru_pkg::xword_type req_mach_epc,
   output logic              rsp_valid,
   output ptru_pkg::exc_type rsp_exc_code,
   output ptru_pkg::priv_type rsp_new_priv,
   output ptru_pkg::xword_type rsp_status_out,
   output ptru_pkg::xword_type rsp_next_pc,
   output logic              rsp_pc_taken,
   output logic              rsp_standby
);
   import ptru_pkg::*;

   logic      req_valid_ff;
   op_type    op_ff;
   priv_type  priv_ff;
   xword_type status_ff;
   xword_type sepc_ff;
   xword_type mepc_ff;

   logic      rsp_valid_ff;
   exc_type   exc_ff,     exc_in;
   priv_type  npriv_ff,   npriv_in;
   xword_type nstatus_ff, nstatus_in;
   xword_type npc_ff,     npc_in;
   logic      taken_ff,   taken_in;
   logic      standby_ff, standby_in;

   logic      accept;
   priv_type  mpp;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign mpp    = status_ff[ST_MPP +: 2];

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= op_type'(req_mode);
         priv_ff   <= req_cur_priv;
         status_ff <= req_status_in;
         sepc_ff   <= req_sup_epc;
         mepc_ff   <= req_mach_epc;
      end
   end

   always_comb begin
      exc_in     = EXC_NONE;
      npriv_in   = priv_ff;
      nstatus_in = status_ff;
      npc_in     = '0;
      taken_in   = 1'b0;
      standby_in = 1'b0;
      case (op_ff)
         OP_ECALL: begin
            case (priv_ff)
               PRIV_U:  exc_in = EXC_ECALL_U;
               PRIV_S:  exc_in = EXC_ECALL_S;
               PRIV_M:  exc_in = EXC_ECALL_M;
               default: exc_in = EXC_ILLEGAL;
            endcase
         end
         OP_SRET: begin
            // tsr only restricts modes below machine; reserved mode ranks above s
            if ((status_ff[ST_TSR] && priv_ff != PRIV_M) || priv_ff == PRIV_U) begin
               exc_in = EXC_ILLEGAL;
            end else begin
               npriv_in                = status_ff[ST_SPP] ? PRIV_S : PRIV_U;
               nstatus_in[ST_SIE]      = status_ff[ST_SPIE];
               nstatus_in[ST_SPIE]     = 1'b1;
               nstatus_in[ST_SPP]      = 1'b0;
               nstatus_in[ST_MPRV]     = 1'b0;
               npc_in                  = sepc_ff;
               taken_in                = 1'b1;
            end
         end
         OP_MRET: begin
            if (priv_ff != PRIV_M) begin
               exc_in = EXC_ILLEGAL;
            end else begin
               npriv_in                = mpp;
               nstatus_in[ST_MIE]      = status_ff[ST_MPIE];
               nstatus_in[ST_MPIE]     = 1'b1;
               nstatus_in[ST_MPP +: 2] = PRIV_U;
               if (mpp != PRIV_M) begin
                  nstatus_in[ST_MPRV] = 1'b0;
               end
               npc_in                  = mepc_ff;
               taken_in                = 1'b1;
            end
         end
         OP_WFI: begin
            if ((status_ff[ST_TW] && priv_ff != PRIV_M) || priv_ff == PRIV_U) begin
               exc_in = EXC_ILLEGAL;
            end else begin
               standby_in = 1'b1;
            end
         end
         default: begin
            exc_in = EXC_ILLEGAL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         exc_ff     <= exc_in;
         npriv_ff   <= npriv_in;
         nstatus_ff <= nstatus_in;
         npc_ff     <= npc_in;
         taken_ff   <= taken_in;
         standby_ff <= standby_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_exc_code   = exc_ff;
   assign rsp_new_priv   = npriv_ff;
   assign rsp_status_out = nstatus_ff;
   assign rsp_next_pc    = npc_ff;
   assign rsp_pc_taken   = taken_ff;
   assign rsp_standby    = standby_ff;

endmodule

// ===== sv/ptru_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptru_checker
// port level checks on the privilege trap and return unit
// ----------------------------------------------------------------------------
module ptru_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input ptru_pkg::exc_type rsp_exc_code,
   input ptru_pkg::xword_type rsp_next_pc,
   input logic              rsp_pc_taken,
   input logic              rsp_standby
);
   import ptru_pkg::*;

   // every transfer gives its result
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("transfer without result two cycles later");

   // no result without an earlier transfer
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(reset) && !$past(reset, 2)) |-> $past(start && !busy, 2))
      else $error("result without a matching transfer");

   a_trap_is_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_exc_code != EXC_NONE) |-> (!rsp_pc_taken && !rsp_standby))
      else $error("trapping instruction redirected or entered standby");

   a_no_redirect_target: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_pc_taken) |-> (rsp_next_pc == '0))
      else $error("next pc not zero without redirect");

   a_redirect_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_pc_taken && rsp_standby))
      else $error("redirect and standby at once");

endmodule

bind privilege_trap_return_unit_core ptru_checker u_ptru_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_exc_code (rsp_exc_code),
   .rsp_next_pc  (rsp_next_pc),
   .rsp_pc_taken (rsp_pc_taken),
   .rsp_standby  (rsp_standby)
);

// ===== tb/privilege_trap_return_unit_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// privilege_trap_return_unit_core_test
// self-checking bench for the ecall / sret / mret / wfi execution unit
// ----------------------------------------------------------------------------
// a directed set hits every operation at every privilege with the trap bits
// set or clear, then random instructions follow with random mstatus and
// return addresses; a local predictor computes each expected result, which
// is checked field by field against the result stream in order, while start
// idles at random with bursts of back-to-back transfers in between
// ----------------------------------------------------------------------------
module privilege_trap_return_unit_core_test;

   import ptru_pkg::*;

   localparam int CLOCK_PERIOD   = 20;
   localparam int RESET_CYCLES   = 7;
   localparam int TOTAL_INSTRS   = 1650;
   localparam int DRAIN_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;

   typedef struct {
      op_type    op;
      priv_type  priv;
      xword_type status;
      xword_type sepc;
      xword_type mepc;
   } sys_instr_type;

   typedef struct {
      exc_type   exc;
      priv_type  new_priv;
      xword_type status;
      xword_type next_pc;
      logic      pc_taken;
      logic      standby;
   } sys_outcome_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   op_type    req_mode = OP_ECALL;
   priv_type  req_cur_priv = PRIV_U;
   xword_type req_status_in = '0;
   xword_type req_sup_epc = '0;
   xword_type req_mach_epc = '0;
   logic      rsp_valid;
   exc_type   rsp_exc_code;
   priv_type  rsp_new_priv;
   xword_type rsp_status_out;
   xword_type rsp_next_pc;
   logic      rsp_pc_taken;
   logic      rsp_standby;

   sys_instr_type   instr_backlog[$];
   sys_outcome_type outcome_fifo[$];
   sys_instr_type   cur_instr;
   sys_outcome_type want;

   int gap_left = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_errors = 0;
   int n_traps = 0;
   int n_redirects = 0;
   int n_standby = 0;
   int n_by_op[4] = '{0, 0, 0, 0};

   privilege_trap_return_unit_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_cur_priv   (req_cur_priv),
      .req_status_in  (req_status_in),
      .req_sup_epc    (req_sup_epc),
      .req_mach_epc   (req_mach_epc),
      .rsp_valid      (rsp_valid),
      .rsp_exc_code   (rsp_exc_code),
      .rsp_new_priv   (rsp_new_priv),
      .rsp_status_out (rsp_status_out),
      .rsp_next_pc    (rsp_next_pc),
      .rsp_pc_taken   (rsp_pc_taken),
      .rsp_standby    (rsp_standby)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic sys_outcome_type predict_outcome(sys_instr_type ins);
      sys_outcome_type r;
      priv_type        mpp;
      r.exc      = EXC_NONE;
      r.new_priv = ins.priv;
      r.status   = ins.status;
      r.next_pc  = '0;
      r.pc_taken = 1'b0;
      r.standby  = 1'b0;
      case (ins.op)
         OP_ECALL: begin
            case (ins.priv)
               PRIV_U:  r.exc = EXC_ECALL_U;
               PRIV_S:  r.exc = EXC_ECALL_S;
               PRIV_M:  r.exc = EXC_ECALL_M;
               default: r.exc = EXC_ILLEGAL;
            endcase
         end
         OP_SRET: begin
            // reserved privilege compares as above supervisor
            if ((ins.status[ST_TSR] && ins.priv != PRIV_M) || ins.priv < PRIV_S) begin
               r.exc = EXC_ILLEGAL;
            end else begin
               r.new_priv            = ins.status[ST_SPP] ? PRIV_S : PRIV_U;
               r.status[ST_SIE]      = ins.status[ST_SPIE];
               r.status[ST_SPIE]     = 1'b1;
               r.status[ST_SPP]      = 1'b0;
               r.status[ST_MPRV]     = 1'b0;
               r.next_pc             = ins.sepc;
               r.pc_taken            = 1'b1;
            end
         end
         OP_MRET: begin
            if (ins.priv != PRIV_M) begin
               r.exc = EXC_ILLEGAL;
            end else begin
               mpp                   = ins.status[ST_MPP +: 2];
               r.new_priv            = mpp;
               r.status[ST_MIE]      = ins.status[ST_MPIE];
               r.status[ST_MPIE]     = 1'b1;
               r.status[ST_MPP +: 2] = 2'b00;
               if (mpp != PRIV_M) r.status[ST_MPRV] = 1'b0;
               r.next_pc             = ins.mepc;
               r.pc_taken            = 1'b1;
            end
         end
         default: begin
            if ((ins.status[ST_TW] && ins.priv != PRIV_M) || ins.priv == PRIV_U) begin
               r.exc = EXC_ILLEGAL;
            end else begin
               r.standby = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   task automatic add_instr(op_type op, priv_type priv, xword_type status,
                            xword_type sepc, xword_type mepc);
      sys_instr_type ins;
      ins.op     = op;
      ins.priv   = priv;
      ins.status = status;
      ins.sepc   = sepc;
      ins.mepc   = mepc;
      instr_backlog.push_back(ins);
   endtask

   task automatic log_error(string msg);
      n_errors++;
      if (n_errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // mostly short gaps, a few long ones, and bursts with no gap at all
   function automatic int next_gap();
      int roll;
      if (burst_left != 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) begin
         burst_left = $urandom_range(20, 80);
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic xword_type random_addr();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // driver: one transfer per accepted start, expectation queued on the transfer
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         gap_left <= 0;
      end else begin
         if (start && !busy) begin
            outcome_fifo.push_back(predict_outcome(cur_instr));
            n_sent++;
         end
         if (start && busy) begin
            // hold the item until it is taken
         end else if (gap_left == 0 && instr_backlog.size() != 0) begin
            cur_instr     = instr_backlog.pop_front();
            req_mode      <= cur_instr.op;
            req_cur_priv  <= cur_instr.priv;
            req_status_in <= cur_instr.status;
            req_sup_epc   <= cur_instr.sepc;
            req_mach_epc  <= cur_instr.mepc;
            start         <= 1'b1;
            gap_left      <= next_gap();
         end else begin
            start <= 1'b0;
            if (gap_left != 0) gap_left <= gap_left - 1;
         end
      end
   end

   // monitor: every strobed result is matched against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (outcome_fifo.size() == 0) begin
            log_error($sformatf({"result with nothing outstanding: ",
                                 "exc %0d priv %0d status %h pc %h"},
                                rsp_exc_code, rsp_new_priv, rsp_status_out, rsp_next_pc));
         end else begin
            want = outcome_fifo.pop_front();
            n_checked++;
            if (want.exc !== EXC_NONE) n_traps++;
            if (want.pc_taken) n_redirects++;
            if (want.standby) n_standby++;
            if (rsp_exc_code !== want.exc || rsp_new_priv !== want.new_priv ||
                rsp_status_out !== want.status || rsp_next_pc !== want.next_pc ||
                rsp_pc_taken !== want.pc_taken || rsp_standby !== want.standby) begin
               log_error($sformatf({"result %0d: expected exc %0d priv %0d status %h pc %h ",
                                    "taken %0b standby %0b, got exc %0d priv %0d status %h ",
                                    "pc %h taken %0b standby %0b"},
                                   n_checked, want.exc, want.new_priv, want.status,
                                   want.next_pc, want.pc_taken, want.standby, rsp_exc_code,
                                   rsp_new_priv, rsp_status_out, rsp_next_pc, rsp_pc_taken,
                                   rsp_standby));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, outcome_fifo.size());
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      xword_type tsr, tw, spp, spie, mpie, mprv, zero, ones;
      xword_type mpp0, mpp1, mpp2, mpp3, key_bits, st;
      op_type    op;
      tsr  = xword_type'(1) << ST_TSR;
      tw   = xword_type'(1) << ST_TW;
      spp  = xword_type'(1) << ST_SPP;
      spie = xword_type'(1) << ST_SPIE;
      mpie = xword_type'(1) << ST_MPIE;
      mprv = xword_type'(1) << ST_MPRV;
      zero = '0;
      ones = '1;
      mpp0 = zero;
      mpp1 = xword_type'(1) << ST_MPP;
      mpp2 = xword_type'(2) << ST_MPP;
      mpp3 = xword_type'(3) << ST_MPP;
      key_bits = tsr | tw | spp | spie | mpie | mprv | mpp3 |
                 (xword_type'(1) << ST_SIE) | (xword_type'(1) << ST_MIE);

      // ecall from each privilege, reserved one traps as illegal
      add_instr(OP_ECALL, PRIV_U, zero, zero, ones);
      add_instr(OP_ECALL, PRIV_S, ones, ones, zero);
      add_instr(OP_ECALL, 2'd2,   zero, zero, ones);
      add_instr(OP_ECALL, PRIV_M, ones, ones, zero);
      // sret: user traps, tsr traps below machine, reserved privilege executes with tsr clear
      add_instr(OP_SRET, PRIV_U, spp | spie, ones, zero);
      add_instr(OP_SRET, PRIV_S, spp | spie | mprv, ones, zero);
      add_instr(OP_SRET, PRIV_S, zero, zero, ones);
      add_instr(OP_SRET, PRIV_S, tsr | spp, ones, ones);
      add_instr(OP_SRET, PRIV_M, tsr | mprv, ones, zero);
      add_instr(OP_SRET, 2'd2,   ones & ~tsr, 32'h8000_0001, zero);
      add_instr(OP_SRET, 2'd2,   tsr | spie, ones, zero);
      // mret: only machine mode, every mpp value, mprv kept only for mpp machine
      add_instr(OP_MRET, PRIV_U, ones, zero, ones);
      add_instr(OP_MRET, PRIV_S, ones, zero, ones);
      add_instr(OP_MRET, 2'd2,   ones, zero, ones);
      add_instr(OP_MRET, PRIV_M, mpp0 | mpie | mprv, zero, ones);
      add_instr(OP_MRET, PRIV_M, mpp1 | mprv, ones, 32'h7fff_fffe);
      add_instr(OP_MRET, PRIV_M, mpp2 | mpie | mprv, zero, ones);
      add_instr(OP_MRET, PRIV_M, mpp3 | mprv, zero, ones);
      add_instr(OP_MRET, PRIV_M, ones, zero, ones);
      // wfi: user traps, tw traps below machine, reserved with tw clear stands by
      add_instr(OP_WFI, PRIV_U, zero, ones, ones);
      add_instr(OP_WFI, PRIV_S, ones & ~tw, zero, zero);
      add_instr(OP_WFI, PRIV_S, tw, zero, zero);
      add_instr(OP_WFI, PRIV_M, ones, ones, ones);
      add_instr(OP_WFI, 2'd2,   zero, zero, zero);
      add_instr(OP_WFI, 2'd2,   tw, ones, ones);

      while (instr_backlog.size() < TOTAL_INSTRS) begin
         op = op_type'($urandom_range(0, 3));
         case ($urandom_range(0, 7))
            0:       st = $urandom & key_bits;
            1:       st = $urandom | ~key_bits;
            default: st = $urandom;
         endcase
         add_instr(op, priv_type'($urandom_range(0, 3)), st, random_addr(), random_addr());
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (instr_backlog.size() != 0 || start || outcome_fifo.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display({"%0d instructions sent (ecall %0d, sret %0d, mret %0d, wfi %0d), ",
                "%0d results checked"},
               n_sent, n_by_op[OP_ECALL], n_by_op[OP_SRET], n_by_op[OP_MRET], n_by_op[OP_WFI],
               n_checked);
      $display("%0d traps, %0d pc redirects, %0d standby requests, %0d mismatches",
               n_traps, n_redirects, n_standby, n_errors);
      if (n_errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // operation mix for the summary, counted on the transfer
   always @(posedge clock) begin
      if (!reset && start && !busy) n_by_op[req_mode]++;
   end

endmodule
